FILE: hdl/a2h_pkg.sv
// shared types and constants for the ascii to hid keystroke serializer
package a2h_pkg;

  typedef enum logic [1:0] {
    CMD_POLL   = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_CUSTOM = 2'd2,
    CMD_TOGGLE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DOWN = 2'd1,
    PH_UP   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    TG_NONE = 2'd0,
    TG_REQ  = 2'd1,
    TG_SENT = 2'd2
  } toggle_t;

  typedef struct packed {
    cmd_t       command;
    logic [6:0] char_code;
    logic [7:0] custom_keycode;
  } cmd_item_t;

  typedef struct packed {
    logic [7:0] modifier_byte;
    logic [7:0] keycode;
    logic       busy_res;
  } rpt_t;

  localparam logic [7:0] MOD_SHIFT = 8'h02;
  localparam logic [7:0] MOD_RALT  = 8'h40;

  localparam logic [7:0] KEY_A     = 8'h04;
  localparam logic [7:0] KEY_1     = 8'h1E;
  localparam logic [7:0] KEY_0     = 8'h27;
  localparam logic [7:0] KEY_ENTER = 8'h28;
  localparam logic [7:0] KEY_SPACE = 8'h2C;
  localparam logic [7:0] KEY_GRAVE = 8'h35;
  localparam logic [7:0] KEY_SLASH = 8'h38;
  localparam logic [7:0] KEY_NONE  = 8'h00;

  localparam logic [6:0] CH_LF      = 7'h0A;
  localparam logic [6:0] CH_SPACE   = 7'h20;
  localparam logic [6:0] CH_BANG    = 7'h21;
  localparam logic [6:0] CH_SLASH   = 7'h2F;
  localparam logic [6:0] CH_ZERO    = 7'h30;
  localparam logic [6:0] CH_ONE     = 7'h31;
  localparam logic [6:0] CH_NINE    = 7'h39;
  localparam logic [6:0] CH_QUEST   = 7'h3F;
  localparam logic [6:0] CH_UPPER_A = 7'h41;
  localparam logic [6:0] CH_UPPER_Z = 7'h5A;
  localparam logic [6:0] CH_LOWER_A = 7'h61;
  localparam logic [6:0] CH_LOWER_Z = 7'h7A;
  localparam logic [6:0] CH_TILDE   = 7'h7E;

endpackage

FILE: hdl/a2h_stream_if.sv
// valid/ready stream interface carrying one payload item per transfer
interface a2h_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/a2h_ram.sv
// generic single write port ram with registered read (old data on collision)
module a2h_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/a2h_keymap.sv
// ascii character to hid usage code and shift lookup
module a2h_keymap
  import a2h_pkg::*;
(
  input  logic [6:0] char_code,
  output logic [7:0] usage,
  output logic       shift
);
  logic [7:0] ch8;

  assign ch8 = {1'b0, char_code};

  always_comb begin
    usage = KEY_NONE;
    shift = 1'b0;
    case (char_code) inside
      [CH_LOWER_A:CH_LOWER_Z]: usage = KEY_A + (ch8 - {1'b0, CH_LOWER_A});
      [CH_UPPER_A:CH_UPPER_Z]: begin
        usage = KEY_A + (ch8 - {1'b0, CH_UPPER_A});
        shift = 1'b1;
      end
      [CH_ONE:CH_NINE]:        usage = KEY_1 + (ch8 - {1'b0, CH_ONE});
      CH_ZERO:                 usage = KEY_0;
      CH_SLASH:                usage = KEY_SLASH;
      CH_SPACE:                usage = KEY_SPACE;
      CH_LF:                   usage = KEY_ENTER;
      CH_BANG: begin
        usage = KEY_1;
        shift = 1'b1;
      end
      CH_QUEST: begin
        usage = KEY_SLASH;
        shift = 1'b1;
      end
      CH_TILDE: begin
        usage = KEY_GRAVE;
        shift = 1'b1;
      end
      default: begin
        usage = KEY_NONE;
        shift = 1'b0;
      end
    endcase
  end
endmodule

FILE: hdl/a2h_out_skid.sv
// two-entry output register with skid stage for report transfers
module a2h_out_skid
  import a2h_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  rpt_t push_data,
  output logic space,
  output logic out_valid,
  input  logic out_ready,
  output rpt_t out_data
);
  logic ov;
  logic sv;
  rpt_t od;
  rpt_t sd;
  logic out_xfer;

  assign space     = !sv;
  assign out_valid = ov;
  assign out_data  = od;
  assign out_xfer  = ov && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (sv) begin
      if (out_xfer) begin
        od <= sd;
        sv <= 1'b0;
      end
    end else if (push) begin
      if (!ov || out_xfer) begin
        od <= push_data;
        ov <= 1'b1;
      end else begin
        sd <= push_data;
        sv <= 1'b1;
      end
    end else if (out_xfer) begin
      ov <= 1'b0;
    end
  end
endmodule

FILE: hdl/ascii_to_hid_keystroke_serializer.sv
// top level: buffers ascii characters and serves hid keyboard reports on host polls
//
// usage
//   cmd carries one command per transfer: host poll, append character, set custom
//   keycode or request a language toggle. only a host poll yields a report on rpt.
//   each report is the one held before that poll; the poll then loads the next
//   key-down or release report into the held registers
// latency and throughput
//   one command per cycle while cmd.ready is high; a poll's report is registered
//   in the output register, or the skid entry if that is full. the rate is set
//   by the state registers, all updated in the transfer cycle, and by the ram
//   read address tracking rd_next, so the head character is registered per poll
// reset
//   rst clears the pointers, phases, pending requests and held report; the
//   character ram is not cleared, only entries below the fill count are read
// stall
//   reports wait in an output register backed by a skid entry; while both are
//   full cmd.ready is low for every command, and no report is lost or repeated
// appends to a full buffer are dropped; the buffer resets when it drains
module ascii_to_hid_keystroke_serializer
  import a2h_pkg::*;
#(
  parameter int BUFFER_DEPTH = 64
) (
  input logic          clk,
  input logic          rst,
  a2h_stream_if.sink   cmd,
  a2h_stream_if.source rpt
);
  // count width holds 0..depth, index width addresses the ram
  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam int AW = $clog2(BUFFER_DEPTH);

  // buffer pointers
  logic [CW-1:0] rd;
  logic [CW-1:0] rd_next;
  logic [CW-1:0] fill;
  logic [CW-1:0] fill_next;

  // keystroke state and held report
  phase_t     phase;
  phase_t     phase_next;
  toggle_t    tphase;
  toggle_t    tphase_next;
  logic [7:0] hmod;
  logic [7:0] hmod_next;
  logic [7:0] hkey;
  logic [7:0] hkey_next;
  logic [7:0] pcustom;
  logic [7:0] pcustom_next;

  // handshake and report path
  logic      accept;
  logic      push;
  logic      space;
  rpt_t      rpt_d;
  cmd_item_t item;

  // character store and head-of-buffer bypass
  logic       we;
  logic [6:0] ram_q;
  logic       byp;
  logic [6:0] byp_data;
  logic [6:0] head;
  logic [7:0] map_usage;
  logic       map_shift;

  assign item      = cmd.data;
  assign cmd.ready = space;
  assign accept    = cmd.valid && space;

  a2h_ram #(
    .WIDTH (7),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (fill[AW-1:0]),
    .wdata (item.char_code),
    .raddr (rd_next[AW-1:0]),
    .rdata (ram_q)
  );

  // a write landing on the entry about to be read is forwarded past the ram
  assign head = byp ? byp_data : ram_q;

  a2h_keymap u_map (
    .char_code (head),
    .usage     (map_usage),
    .shift     (map_shift)
  );

  // command decode and poll update, steps in the same order as the keystroke rules
  always_comb begin
    rd_next      = rd;
    fill_next    = fill;
    phase_next   = phase;
    tphase_next  = tphase;
    hmod_next    = hmod;
    hkey_next    = hkey;
    pcustom_next = pcustom;
    we           = 1'b0;
    push         = 1'b0;
    rpt_d        = '0;
    if (accept) begin
      case (item.command)
        CMD_APPEND: begin
          if (fill < CW'(BUFFER_DEPTH)) begin
            we        = 1'b1;
            fill_next = fill + CW'(1);
          end
        end
        CMD_CUSTOM: pcustom_next = item.custom_keycode;
        CMD_TOGGLE: tphase_next = TG_REQ;
        CMD_POLL: begin
          push                = 1'b1;
          rpt_d.modifier_byte = hmod;
          rpt_d.keycode       = hkey;
          // drained buffer returns to empty
          if (rd >= fill) begin
            hmod_next = '0;
            hkey_next = '0;
            rd_next   = '0;
            fill_next = '0;
          end
          // release phases clear the report and drop pending requests
          if (phase == PH_DOWN || phase == PH_UP) begin
            phase_next   = (phase == PH_DOWN) ? PH_UP : PH_IDLE;
            hmod_next    = '0;
            hkey_next    = '0;
            pcustom_next = '0;
            tphase_next  = TG_NONE;
          end else begin
            phase_next = PH_IDLE;
          end
          // next buffered character
          if (phase_next == PH_IDLE && rd_next < fill_next) begin
            hmod_next  = (hmod_next & ~MOD_SHIFT) | (map_shift ? MOD_SHIFT : 8'h00);
            hkey_next  = map_usage;
            rd_next    = rd_next + CW'(1);
            phase_next = PH_DOWN;
          end
          // custom keycode when no character went out
          if (phase_next == PH_IDLE && pcustom_next != 8'h00) begin
            hkey_next  = pcustom_next;
            phase_next = PH_DOWN;
          end
          // language toggle through right alt
          if (phase_next == PH_IDLE && tphase_next == TG_REQ) begin
            hmod_next   = hmod_next | MOD_RALT;
            phase_next  = PH_DOWN;
            tphase_next = TG_SENT;
          end
          rpt_d.busy_res = (fill_next > rd_next) || (phase_next != PH_IDLE)
                           || (pcustom_next != 8'h00) || (tphase_next == TG_REQ);
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd      <= '0;
      fill    <= '0;
      phase   <= PH_IDLE;
      tphase  <= TG_NONE;
      hmod    <= '0;
      hkey    <= '0;
      pcustom <= '0;
      byp     <= 1'b0;
    end else begin
      rd      <= rd_next;
      fill    <= fill_next;
      phase   <= phase_next;
      tphase  <= tphase_next;
      hmod    <= hmod_next;
      hkey    <= hkey_next;
      pcustom <= pcustom_next;
      byp     <= we && (fill == rd_next);
    end
    byp_data <= item.char_code;
  end

  // report output register with skid entry
  a2h_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (rpt_d),
    .space     (space),
    .out_valid (rpt.valid),
    .out_ready (rpt.ready),
    .out_data  (rpt.data)
  );

  // read position never passes the fill count
  a_rd_le_fill: assert property (@(posedge clk) disable iff (rst) rd <= fill)
    else $error("read position beyond fill count");

  // fill count stays within the buffer
  a_fill_le_depth: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(BUFFER_DEPTH))
    else $error("fill count beyond buffer depth");

  // a poll after a key-down loads a release report
  a_release: assert property (@(posedge clk) disable iff (rst)
    (push && phase == PH_DOWN) |=> (hmod == 8'h00 && hkey == 8'h00 && phase == PH_UP))
    else $error("key-down not followed by release report");

  // a sent toggle only exists while its key-down report is held
  a_toggle_sent: assert property (@(posedge clk) disable iff (rst)
    (tphase == TG_SENT) |-> (phase == PH_DOWN))
    else $error("toggle sent outside key-down phase");

endmodule

FILE: tb/tb_ascii_to_hid_keystroke_serializer.sv
// testbench: random and directed command streams against a cycle-free keystroke predictor
`timescale 1ns / 100ps

module tb_ascii_to_hid_keystroke_serializer
  import a2h_pkg::*;
();

  localparam int BUF_DEPTH    = 64;
  localparam int WATCHDOG_MAX = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_ITEMS  = 150;
  localparam int DIR_N        = 27;

  // one directed step: the command and, where it is obvious, the report it must give
  typedef struct packed {
    cmd_item_t item;
    logic      typed;
    rpt_t      rpt;
  } step_t;

  logic clk;
  logic rst;

  a2h_stream_if #(.T(cmd_item_t)) cmd_if ();
  a2h_stream_if #(.T(rpt_t))      rpt_if ();

  ascii_to_hid_keystroke_serializer #(
    .BUFFER_DEPTH(BUF_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_if),
    .rpt(rpt_if)
  );

  // shadow copy of the keystroke state
  logic [6:0]  shadow_chars [BUF_DEPTH];
  int unsigned shadow_rd;
  int unsigned shadow_fill;
  phase_t      shadow_phase;
  logic [7:0]  shadow_mod;
  logic [7:0]  shadow_key;
  logic [7:0]  shadow_custom;
  toggle_t     shadow_toggle;

  rpt_t        pending_reports [$];
  rpt_t        got_rpt;
  rpt_t        want_rpt;
  int          err_count;
  int          items_sent;
  int          tx_idle_pct;
  int          rx_stall_pct;
  int          hold_left;
  int          stall_cycles;
  step_t       directed_steps [DIR_N];

  always #1 clk = ~clk;

  // ascii to usage code, with the shift flag for characters that need it
  function automatic logic [7:0] usage_of(input logic [6:0] c, output bit shifted);
    shifted = 1'b0;
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) return KEY_A + (c - CH_LOWER_A);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      shifted = 1'b1;
      return KEY_A + (c - CH_UPPER_A);
    end
    if (c >= CH_ONE && c <= CH_NINE) return KEY_1 + (c - CH_ONE);
    if (c == CH_ZERO)  return KEY_0;
    if (c == CH_SLASH) return KEY_SLASH;
    if (c == CH_SPACE) return KEY_SPACE;
    if (c == CH_LF)    return KEY_ENTER;
    if (c == CH_BANG) begin
      shifted = 1'b1;
      return KEY_1;
    end
    if (c == CH_QUEST) begin
      shifted = 1'b1;
      return KEY_SLASH;
    end
    if (c == CH_TILDE) begin
      shifted = 1'b1;
      return KEY_GRAVE;
    end
    return KEY_NONE;
  endfunction

  // a host poll: returns the held report, then loads the next one
  function automatic rpt_t next_hid_report();
    rpt_t       r;
    bit         shifted;
    logic [7:0] code;
    r.modifier_byte = shadow_mod;
    r.keycode       = shadow_key;
    // buffer drained, so both pointers restart
    if (shadow_rd >= shadow_fill) begin
      shadow_mod  = 8'h00;
      shadow_key  = KEY_NONE;
      shadow_rd   = 0;
      shadow_fill = 0;
    end
    // a release phase swallows any request made meanwhile
    if (shadow_phase != PH_IDLE) begin
      shadow_phase  = (shadow_phase == PH_DOWN) ? PH_UP : PH_IDLE;
      shadow_mod    = 8'h00;
      shadow_key    = KEY_NONE;
      shadow_custom = 8'h00;
      shadow_toggle = TG_NONE;
    end
    if (shadow_phase == PH_IDLE && shadow_rd < shadow_fill) begin
      code = usage_of(shadow_chars[shadow_rd], shifted);
      shadow_mod   = shifted ? (shadow_mod | MOD_SHIFT) : (shadow_mod & ~MOD_SHIFT);
      shadow_key   = code;
      shadow_rd++;
      shadow_phase = PH_DOWN;
    end
    if (shadow_phase == PH_IDLE && shadow_custom != 8'h00) begin
      shadow_key   = shadow_custom;
      shadow_phase = PH_DOWN;
    end
    if (shadow_phase == PH_IDLE && shadow_toggle == TG_REQ) begin
      shadow_mod    = shadow_mod | MOD_RALT;
      shadow_phase  = PH_DOWN;
      shadow_toggle = TG_SENT;
    end
    r.busy_res = (shadow_fill > shadow_rd) || (shadow_phase != PH_IDLE) ||
                 (shadow_custom != 8'h00) || (shadow_toggle == TG_REQ);
    return r;
  endfunction

  function automatic step_t dir_row(cmd_t c, logic [6:0] ch, logic [7:0] ck, bit typed,
                                    logic [7:0] m, logic [7:0] k, bit b);
    step_t s;
    s.item.command        = c;
    s.item.char_code      = ch;
    s.item.custom_keycode = ck;
    s.typed               = typed;
    s.rpt.modifier_byte   = m;
    s.rpt.keycode         = k;
    s.rpt.busy_res        = b;
    return s;
  endfunction

  // mostly mapped characters, the rest anything in 7 bits
  function automatic logic [6:0] pick_char();
    case ($urandom_range(9))
      0, 1:    return CH_LOWER_A + 7'($urandom_range(25));
      2, 3:    return CH_UPPER_A + 7'($urandom_range(25));
      4:       return CH_ZERO + 7'($urandom_range(9));
      5, 6: begin
        case ($urandom_range(5))
          0:       return CH_SLASH;
          1:       return CH_SPACE;
          2:       return CH_LF;
          3:       return CH_BANG;
          4:       return CH_QUEST;
          default: return CH_TILDE;
        endcase
      end
      default: return 7'($urandom_range(127));
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    err_count++;
  endtask

  // offer one command, entered and left at a falling edge
  task automatic send_cmd(cmd_item_t it, bit typed, rpt_t fixed);
    rpt_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= it;
    do @(posedge clk); while (!cmd_if.ready);
    // transfer done at this edge, so update the shadow state
    case (it.command)
      CMD_POLL: begin
        r = next_hid_report();
        if (typed) r = fixed;
        pending_reports.push_back(r);
      end
      CMD_APPEND: begin
        if (shadow_fill < BUF_DEPTH) begin
          shadow_chars[shadow_fill] = it.char_code;
          shadow_fill++;
        end
      end
      CMD_CUSTOM: shadow_custom = it.custom_keycode;
      default:    shadow_toggle = TG_REQ;
    endcase
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_plain(cmd_t c, logic [6:0] ch, logic [7:0] ck);
    cmd_item_t it;
    it.command        = c;
    it.char_code      = ch;
    it.custom_keycode = ck;
    send_cmd(it, 1'b0, '0);
  endtask

  task automatic send_polls(int n);
    repeat (n) send_plain(CMD_POLL, 7'($urandom_range(127)), 8'($urandom_range(255)));
  endtask

  // a typed word followed by enough polls to play it out
  task automatic send_word();
    int n;
    n = ($urandom_range(24) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 6);
    repeat (n) send_plain(CMD_APPEND, pick_char(), 8'($urandom_range(255)));
    send_polls(2 * ((n > BUF_DEPTH) ? BUF_DEPTH : n) + $urandom_range(3));
  endtask

  task automatic send_custom();
    send_plain(CMD_CUSTOM, 7'($urandom_range(127)),
               ($urandom_range(5) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
    // second write, zero here withdraws the first
    if ($urandom_range(3) == 0)
      send_plain(CMD_CUSTOM, 7'($urandom_range(127)),
                 $urandom_range(1) ? 8'h00 : 8'($urandom_range(255)));
    send_polls($urandom_range(2, 4));
  endtask

  task automatic send_toggle();
    send_plain(CMD_TOGGLE, 7'($urandom_range(127)), 8'($urandom_range(255)));
    send_polls(1);
    // request while the toggle is still down
    if ($urandom_range(2) == 0)
      send_plain(CMD_TOGGLE, 7'($urandom_range(127)), 8'($urandom_range(255)));
    send_polls($urandom_range(2, 3));
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 4))
      send_plain(cmd_t'($urandom_range(3)), 7'($urandom_range(127)),
                 8'($urandom_range(255)));
  endtask

  task automatic run_phase(int tx_pct, int rx_pct);
    int stop_at;
    int pick;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    stop_at      = items_sent + PHASE_ITEMS;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 55)      send_word();
      else if (pick < 67) send_custom();
      else if (pick < 77) send_toggle();
      else if (pick < 85) begin
        // competing requests while characters are queued
        send_plain(CMD_APPEND, pick_char(), 8'($urandom_range(255)));
        send_plain(CMD_CUSTOM, 7'($urandom_range(127)), 8'($urandom_range(255)));
        send_plain(CMD_TOGGLE, 7'($urandom_range(127)), 8'($urandom_range(255)));
        send_polls($urandom_range(2, 7));
      end
      else send_noise();
    end
  endtask

  // receiver side: random stalls, plus a long hold-off counted down here
  initial begin
    rpt_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        rpt_if.ready <= 1'b0;
        hold_left--;
      end else begin
        rpt_if.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // report checker
  always @(posedge clk) begin
    if (!rst && rpt_if.valid && rpt_if.ready) begin
      got_rpt = rpt_if.data;
      if (pending_reports.size() == 0) begin
        report_mismatch("report with none expected, keycode", got_rpt.keycode, KEY_NONE);
      end else begin
        want_rpt = pending_reports.pop_front();
        if (got_rpt.modifier_byte !== want_rpt.modifier_byte)
          report_mismatch("modifier_byte", got_rpt.modifier_byte, want_rpt.modifier_byte);
        if (got_rpt.keycode !== want_rpt.keycode)
          report_mismatch("keycode", got_rpt.keycode, want_rpt.keycode);
        if (got_rpt.busy_res !== want_rpt.busy_res)
          report_mismatch("busy_res", {7'b0, got_rpt.busy_res}, {7'b0, want_rpt.busy_res});
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (cmd_if.valid && cmd_if.ready) || (rpt_if.valid && rpt_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_MAX) begin
      $display("watchdog: no transfer for %0d cycles", stall_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    cmd_if.valid   = 1'b0;
    cmd_if.data    = '0;
    err_count      = 0;
    items_sent     = 0;
    tx_idle_pct    = 0;
    rx_stall_pct   = 0;
    hold_left      = 0;
    stall_cycles   = 0;
    shadow_rd      = 0;
    shadow_fill    = 0;
    shadow_phase   = PH_IDLE;
    shadow_mod     = 8'h00;
    shadow_key     = KEY_NONE;
    shadow_custom  = 8'h00;
    shadow_toggle  = TG_NONE;

    // directed: reset state, shifted and unmapped keys, drain, custom, toggle,
    // custom cleared by zero, and requests dropped during a release phase
    directed_steps = '{
      dir_row(CMD_POLL,   7'h00,      8'h00, 1, 8'h00,     KEY_NONE,  0),
      dir_row(CMD_APPEND, CH_UPPER_Z, 8'h00, 0, 8'h00,     KEY_NONE,  0),
      dir_row(CMD_APPEND, 7'h7F,      8'h00, 0, 8'h00,     KEY_NONE,  0),
      dir_row(CMD_APPEND, CH_TILDE,   8'hFF, 0, 8'h00,     KEY_NONE,  0),
      dir_row(CMD_POLL,   7'h7F,      8'hFF, 0, 8'h00,     KEY_NONE,  0),
      dir_row(CMD_POLL,   7'h00,      8'h00, 1, MOD_SHIFT, 8'h1D,     1),
      dir_row(CMD_POLL,   7'h00,      8'h00, 0, 8'h00,     KEY_NONE,  0),
      dir_row(CMD_POLL,   7'h00,      8'h00, 0, 8'h00,     KEY_NONE,  0),
      dir_row(CMD_POLL,   7'h00,      8'h00, 0, 8'h00,     KEY_NONE,  0),
      dir_row(CMD_POLL,   7'h00,      8'h00, 1, MOD_SHIFT, KEY_GRAVE, 1),
      dir_row(CMD_POLL,   7'h00,      8'h00, 1, 8'h00,     KEY_NONE,  0),
      dir_row(CMD_CUSTOM, 7'h00,      8'hFF, 0, 8'h00,     KEY_NONE,  0),
      dir_row(CMD_POLL,   7'h00,      8'h00, 0, 8'h00,     KEY_NONE,  0),
      dir_row(CMD_POLL,   7'h00,      8'h00, 1, 8'h00,     8'hFF,     1),
      dir_row(CMD_POLL,   7'h00,      8'h00, 1, 8'h00,     KEY_NONE,  0),
      dir_row(CMD_TOGGLE, 7'h00,      8'h00, 0, 8'h00,     KEY_NONE,  0),
      dir_row(CMD_POLL,   7'h00,      8'h00, 0, 8'h00,     KEY_NONE,  0),
      dir_row(CMD_POLL,   7'h00,      8'h00, 1, MOD_RALT,  KEY_NONE,  1),
      dir_row(CMD_POLL,   7'h00,      8'h00, 1, 8'h00,     KEY_NONE,  0),
      dir_row(CMD_CUSTOM, 7'h00,      8'h12, 0, 8'h00,     KEY_NONE,  0),
      dir_row(CMD_CUSTOM, 7'h00,      8'h00, 0, 8'h00,     KEY_NONE,  0),
      dir_row(CMD_POLL,   7'h00,      8'h00, 1, 8'h00,     KEY_NONE,  0),
      dir_row(CMD_CUSTOM, 7'h00,      8'h55, 0, 8'h00,     KEY_NONE,  0),
      dir_row(CMD_POLL,   7'h00,      8'h00, 0, 8'h00,     KEY_NONE,  0),
      dir_row(CMD_TOGGLE, 7'h00,      8'h00, 0, 8'h00,     KEY_NONE,  0),
      dir_row(CMD_POLL,   7'h00,      8'h00, 1, 8'h00,     8'h55,     1),
      dir_row(CMD_POLL,   7'h00,      8'h00, 1, 8'h00,     KEY_NONE,  0)
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_steps[i])
      send_cmd(directed_steps[i].item, directed_steps[i].typed, directed_steps[i].rpt);

    // long receiver hold-off while polls keep coming, so the input stalls
    hold_left = HOLD_CYCLES;
    send_polls(12);
    send_word();

    run_phase(0, 0);
    run_phase(86, 0);
    run_phase(0, 86);
    run_phase(30, 30);

    cmd_if.valid <= 1'b0;
    rx_stall_pct = 0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
